[src/bed_pkg.sv]
`timescale 1ns / 1ps
// Package with the shared types, character codes and helper functions of the escape decoder.
package bed_pkg;

    // Depth of the queue between the classifying front and the output back end.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Source characters that the decoder recognizes.
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
    localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
    localparam logic [7:0] CHAR_LC_A      = 8'h61;
    localparam logic [7:0] CHAR_LC_B      = 8'h62;
    localparam logic [7:0] CHAR_LC_F      = 8'h66;
    localparam logic [7:0] CHAR_LC_N      = 8'h6E;
    localparam logic [7:0] CHAR_LC_R      = 8'h72;
    localparam logic [7:0] CHAR_LC_T      = 8'h74;
    localparam logic [7:0] CHAR_LC_V      = 8'h76;
    localparam logic [7:0] CHAR_LC_X      = 8'h78;
    localparam logic [7:0] CHAR_0         = 8'h30;
    localparam logic [7:0] CHAR_7         = 8'h37;
    localparam logic [7:0] CHAR_9         = 8'h39;
    localparam logic [7:0] CHAR_UC_A      = 8'h41;
    localparam logic [7:0] CHAR_UC_F      = 8'h46;

    // Control codes produced by the simple escapes.
    localparam logic [7:0] CODE_BEL = 8'd7;
    localparam logic [7:0] CODE_BS  = 8'd8;
    localparam logic [7:0] CODE_FF  = 8'd12;
    localparam logic [7:0] CODE_LF  = 8'd10;
    localparam logic [7:0] CODE_CR  = 8'd13;
    localparam logic [7:0] CODE_HT  = 8'd9;
    localparam logic [7:0] CODE_VT  = 8'd11;

    // Decoder phase, one-hot.
    typedef enum logic [5:0] {
        PH_PLAIN   = 6'b000001,
        PH_ESC     = 6'b000010,
        PH_OCT     = 6'b000100,
        PH_HEX1    = 6'b001000,
        PH_HEX2    = 6'b010000,
        PH_DISCARD = 6'b100000
    } phase_t;

    // One queue entry: the one or two result transfers caused by one source byte.
    typedef struct packed {
        logic       two;
        logic [7:0] byte0;
        logic       bad0;
        logic       end0;
        logic [7:0] byte1;
        logic       end1;
    } bed_entry_t;

    // Simple escape lookup: returns {hit, decoded value}.
    function automatic logic [8:0] simple_escape(input logic [7:0] c);
        logic [8:0] r;
        r = {1'b0, c};
        case (c)
            CHAR_LC_A:      r = {1'b1, CODE_BEL};
            CHAR_LC_B:      r = {1'b1, CODE_BS};
            CHAR_LC_F:      r = {1'b1, CODE_FF};
            CHAR_LC_N:      r = {1'b1, CODE_LF};
            CHAR_LC_R:      r = {1'b1, CODE_CR};
            CHAR_LC_T:      r = {1'b1, CODE_HT};
            CHAR_LC_V:      r = {1'b1, CODE_VT};
            CHAR_SQUOTE,
            CHAR_DQUOTE,
            CHAR_BACKSLASH: r = {1'b1, c};
            default:        r = {1'b0, c};
        endcase
        return r;
    endfunction

    // Hex digit lookup: returns {valid, nibble}.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[CHAR_0:CHAR_9]}) begin
            d = c - CHAR_0;
            r = {1'b1, d[3:0]};
        end else if (c inside {[CHAR_UC_A:CHAR_UC_F]}) begin
            d = c - CHAR_UC_A;
            r = {1'b1, d[3:0] + 4'd10};
        end else if (c inside {[CHAR_LC_A:CHAR_LC_F]}) begin
            d = c - CHAR_LC_A;
            r = {1'b1, d[3:0] + 4'd10};
        end else begin
            d = c;
            r = {1'b0, 4'd0};
        end
        return r;
    endfunction

endpackage

[src/bed_if.sv]
`timescale 1ns / 1ps
// Handshake interfaces for the source text, decoded output and configuration channels.
interface bed_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface bed_dec_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       bad_escape;
    logic       end_of_string;

    modport source (output valid, output out_byte, output bad_escape, output end_of_string,
                    input ready);
    modport sink   (input valid, input out_byte, input bad_escape, input end_of_string,
                    output ready);
endinterface

interface bed_cfg_if;
    logic valid;
    logic ready;
    logic raw_mode;

    modport source (output valid, output raw_mode, input ready);
    modport sink   (input valid, input raw_mode, output ready);
endinterface

[src/bytes_escape_decoder_unit.sv]
`timescale 1ns / 1ps
// Top level of the bytes literal escape decoder.
//
// The block decodes the source text of a bytes literal, one byte per transfer on
// the text channel (in_byte with in_last on the final byte of the literal), and
// delivers decoded bytes on the decoded channel with end_of_string on the final
// result of each literal. A malformed hex escape yields a single transfer with
// bad_escape set, and the rest of that literal yields nothing.
// The cfg channel writes raw_mode; it is always ready and should only be written
// while the block is idle. With raw_mode set, bytes pass through unchanged.
// An accepted text transfer passes through the queue and the output register to the
// decoded channel. One text transfer is taken every cycle unless the queue is full;
// a byte with two results (an unknown escape, or an octal escape closed by a plain
// byte) goes as two transfers through the single output register, which sets the pace.
// A four-entry queue sits between the classifying front end and the output stage,
// so the text channel keeps flowing while the receiver stalls until the queue fills.
// Reset clears the decoder phase, the raw_mode register, the queue and the output
// valid flag; the block is ready for text on the first cycle after reset.
module bytes_escape_decoder_unit
    import bed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bed_text_if.sink   text,
    bed_cfg_if.sink    cfg,
    bed_dec_if.source  decoded
);

    logic       push;
    bed_entry_t push_entry;
    logic       pop;
    bed_entry_t head;
    logic       full;
    logic       empty;

    // Escape state machine; pushes one entry per byte that produces output.
    bed_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .cfg        (cfg),
        .full       (full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decoupling queue between classification and delivery.
    bed_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (full),
        .empty      (empty)
    );

    // Output stage that issues each entry as one or two transfers.
    bed_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .empty   (empty),
        .pop     (pop),
        .decoded (decoded)
    );

endmodule

[src/bed_front.sv]
`timescale 1ns / 1ps
// Front end: takes source bytes, runs the escape state machine and queues the results.
module bed_front
    import bed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bed_text_if.sink   text,
    bed_cfg_if.sink    cfg,
    input  logic       full,
    output logic       push,
    output bed_entry_t push_entry
);

    logic       raw_mode_reg;
    phase_t     phase_reg, phase_next;
    logic [7:0] oct_val_reg, oct_val_next;
    logic [1:0] oct_cnt_reg, oct_cnt_next;
    logic [3:0] nib_reg, nib_next;
    logic       accept;
    logic [7:0] b;
    logic       last;
    logic [8:0] simple;
    logic [4:0] hex;
    logic [7:0] oct_new;
    bed_entry_t entry;
    logic       emit;

    assign text.ready = !full;
    assign cfg.ready  = 1'b1;
    assign accept     = text.valid && text.ready;
    assign b          = text.in_byte;
    assign last       = text.in_last;
    assign simple     = simple_escape(b);
    assign hex        = hex_digit(b);
    assign oct_new    = {oct_val_reg[4:0], b[2:0]};

    always_comb
    begin
        phase_next   = phase_reg;
        oct_val_next = oct_val_reg;
        oct_cnt_next = oct_cnt_reg;
        nib_next     = nib_reg;
        emit         = 1'b0;
        entry        = '0;
        if (raw_mode_reg) begin
            phase_next   = PH_PLAIN;
            oct_val_next = 8'd0;
            oct_cnt_next = 2'd0;
            nib_next     = 4'd0;
            emit         = 1'b1;
            entry.byte0  = b;
            entry.end0   = last;
        end else begin
            case (phase_reg)
                PH_ESC:
                begin
                    phase_next = PH_PLAIN;
                    if (simple[8]) begin
                        emit        = 1'b1;
                        entry.byte0 = simple[7:0];
                        entry.end0  = last;
                    end else if (b == CHAR_LC_X) begin
                        if (last) begin
                            emit       = 1'b1;
                            entry.bad0 = 1'b1;
                            entry.end0 = 1'b1;
                        end else begin
                            phase_next = PH_HEX1;
                        end
                    end else if (b inside {[CHAR_0:CHAR_7]}) begin
                        if (last) begin
                            emit        = 1'b1;
                            entry.byte0 = {5'd0, b[2:0]};
                            entry.end0  = 1'b1;
                        end else begin
                            phase_next   = PH_OCT;
                            oct_val_next = {5'd0, b[2:0]};
                            oct_cnt_next = 2'd1;
                        end
                    end else begin
                        // Unknown escape keeps the backslash and the character.
                        emit        = 1'b1;
                        entry.two   = 1'b1;
                        entry.byte0 = CHAR_BACKSLASH;
                        entry.byte1 = b;
                        entry.end1  = last;
                    end
                end
                PH_OCT:
                begin
                    if (b inside {[CHAR_0:CHAR_7]}) begin
                        if (oct_cnt_reg == 2'd2 || last) begin
                            emit         = 1'b1;
                            entry.byte0  = oct_new;
                            entry.end0   = last;
                            phase_next   = PH_PLAIN;
                            oct_val_next = 8'd0;
                            oct_cnt_next = 2'd0;
                        end else begin
                            oct_val_next = oct_new;
                            oct_cnt_next = oct_cnt_reg + 2'd1;
                        end
                    end else begin
                        // Octal ended early: flush the value, then treat the byte as text.
                        emit         = 1'b1;
                        entry.byte0  = oct_val_reg;
                        oct_val_next = 8'd0;
                        oct_cnt_next = 2'd0;
                        if (b == CHAR_BACKSLASH && !last) begin
                            phase_next = PH_ESC;
                        end else begin
                            phase_next  = PH_PLAIN;
                            entry.two   = 1'b1;
                            entry.byte1 = b;
                            entry.end1  = last;
                        end
                    end
                end
                PH_HEX1:
                begin
                    if (!hex[4] || last) begin
                        emit         = 1'b1;
                        entry.bad0   = 1'b1;
                        entry.end0   = 1'b1;
                        phase_next   = last ? PH_PLAIN : PH_DISCARD;
                        oct_val_next = 8'd0;
                        oct_cnt_next = 2'd0;
                        nib_next     = 4'd0;
                    end else begin
                        nib_next   = hex[3:0];
                        phase_next = PH_HEX2;
                    end
                end
                PH_HEX2:
                begin
                    emit     = 1'b1;
                    nib_next = 4'd0;
                    if (!hex[4]) begin
                        entry.bad0   = 1'b1;
                        entry.end0   = 1'b1;
                        phase_next   = last ? PH_PLAIN : PH_DISCARD;
                        oct_val_next = 8'd0;
                        oct_cnt_next = 2'd0;
                    end else begin
                        entry.byte0 = {nib_reg, hex[3:0]};
                        entry.end0  = last;
                        phase_next  = PH_PLAIN;
                    end
                end
                PH_DISCARD:
                begin
                    if (last) begin
                        phase_next = PH_PLAIN;
                    end
                end
                default:
                begin
                    if (b == CHAR_BACKSLASH && !last) begin
                        phase_next = PH_ESC;
                    end else begin
                        phase_next  = PH_PLAIN;
                        emit        = 1'b1;
                        entry.byte0 = b;
                        entry.end0  = last;
                    end
                end
            endcase
        end
    end

    assign push       = accept && emit;
    assign push_entry = entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            raw_mode_reg <= 1'b0;
            phase_reg    <= PH_PLAIN;
            oct_val_reg  <= 8'd0;
            oct_cnt_reg  <= 2'd0;
            nib_reg      <= 4'd0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                raw_mode_reg <= cfg.raw_mode;
            end
            if (accept) begin
                phase_reg   <= phase_next;
                oct_val_reg <= oct_val_next;
                oct_cnt_reg <= oct_cnt_next;
                nib_reg     <= nib_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_bad_ends_string: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_entry.bad0 |-> push_entry.end0 && !push_entry.two)
        else $error("error result without end of string");
    a_oct_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_OCT |-> (oct_cnt_reg == 2'd1 || oct_cnt_reg == 2'd2))
        else $error("octal digit count out of range");
`endif

endmodule

[src/bed_fifo.sv]
`timescale 1ns / 1ps
// Short queue of result entries between the front end and the back end.
module bed_fifo
    import bed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  bed_entry_t push_entry,
    input  logic       pop,
    output bed_entry_t head,
    output logic       full,
    output logic       empty
);

    bed_entry_t           mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg;

    assign full  = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= FIFO_AW'((32'(wr_ptr_reg) + 1) % FIFO_DEPTH);
            end
            if (pop) begin
                rd_ptr_reg <= FIFO_AW'((32'(rd_ptr_reg) + 1) % FIFO_DEPTH);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");
`endif

endmodule

[src/bed_back.sv]
`timescale 1ns / 1ps
// Back end: unpacks queue entries into one or two output transfers behind an output register.
module bed_back
    import bed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  bed_entry_t head,
    input  logic       empty,
    output logic       pop,
    bed_dec_if.source  decoded
);

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_bad_reg;
    logic       out_end_reg;
    logic       pend_reg;
    logic [7:0] pend_byte_reg;
    logic       pend_end_reg;
    logic       load;

    assign load = !out_valid_reg || decoded.ready;
    assign pop  = load && !pend_reg && !empty;

    assign decoded.valid         = out_valid_reg;
    assign decoded.out_byte      = out_byte_reg;
    assign decoded.bad_escape    = out_bad_reg;
    assign decoded.end_of_string = out_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end else if (load) begin
            if (pend_reg) begin
                out_valid_reg <= 1'b1;
                pend_reg      <= 1'b0;
            end else begin
                out_valid_reg <= !empty;
                pend_reg      <= !empty && head.two;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            if (pend_reg) begin
                out_byte_reg <= pend_byte_reg;
                out_bad_reg  <= 1'b0;
                out_end_reg  <= pend_end_reg;
            end else if (!empty) begin
                out_byte_reg  <= head.byte0;
                out_bad_reg   <= head.bad0;
                out_end_reg   <= head.end0;
                pend_byte_reg <= head.byte1;
                pend_end_reg  <= head.end1;
            end
        end
    end

`ifndef SYNTHESIS
    a_pend_has_first: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> out_valid_reg)
        else $error("second result pending without a first one on the output");
`endif

endmodule
